@@ src/shfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sync-header frame receiver package
// Shared types and constants for the frame receiver: sync pattern, header
// layout, register map and the payload structures passed between modules.
// ----------------------------------------------------------------------------
package shfr_pkg;

  // Sync pair that opens a frame.
  localparam logic [7:0] SyncFirst  = 8'hEB;
  localparam logic [7:0] SyncSecond = 8'h90;

  // Frame positions are nine bits wide (length byte plus overhead reaches 258).
  localparam int unsigned PosWidth = 9;

  // Index of the length byte and the header overhead added to the length.
  localparam logic [PosWidth-1:0] LenPos         = 9'd2;
  localparam logic [PosWidth-1:0] HeaderOverhead = 9'd3;

  // Configuration port geometry and register map.
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic [0:0]  RegResyncTimeout = 1'b0;
  localparam logic [15:0] ResyncTimeoutReset = 16'd2;

  // Configuration held by the register block.
  typedef struct packed {
    logic [15:0] resync_timeout;
  } cfg_t;

  // One received byte with its timestamp, as held in the input register.
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
  } item_t;

  // One result, as held in the result register.
  typedef struct packed {
    logic                wr_valid;
    logic [PosWidth-1:0] wr_index;
    logic [7:0]          wr_data;
    logic                frame_done;
    logic                frame_good;
    logic                in_frame;
  } result_t;

endpackage

@@ src/shfr_if.sv @@
// ----------------------------------------------------------------------------
// Sync-header frame receiver channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface shfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_ms;

  modport source (output valid, output rx_byte, output time_ms, input ready);
  modport sink (input valid, input rx_byte, input time_ms, output ready);
endinterface

interface shfr_out_if;
  logic       valid;
  logic       ready;
  logic       wr_valid;
  logic [8:0] wr_index;
  logic [7:0] wr_data;
  logic       frame_done;
  logic       frame_good;
  logic       in_frame;

  modport source (output valid, output wr_valid, output wr_index, output wr_data,
                  output frame_done, output frame_good, output in_frame, input ready);
  modport sink (input valid, input wr_valid, input wr_index, input wr_data,
                input frame_done, input frame_good, input in_frame, output ready);
endinterface

@@ src/shfr_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register block holding the resynchronisation timeout.
// ----------------------------------------------------------------------------
module shfr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shfr_pkg::AddrWidth-1:0] paddr,
  input  logic [shfr_pkg::DataWidth-1:0] pwdata,
  output logic [shfr_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output shfr_pkg::cfg_t                 cfg_o
);
  import shfr_pkg::*;

  logic [15:0] timeout_q;
  logic        sel_timeout;

  // The word index selects the register; byte lanes within a word are ignored.
  assign sel_timeout = (paddr[AddrWidth-1:2] == RegResyncTimeout);
  assign pready      = 1'b1;

  // Register write on the access phase of a write request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ResyncTimeoutReset;
    end else if (psel && penable && pwrite && sel_timeout) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (sel_timeout) begin
      prdata = {{(DataWidth-16){1'b0}}, timeout_q};
    end
  end

  assign cfg_o.resync_timeout = timeout_q;

endmodule

@@ src/shfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register
// Captures one received byte and its timestamp per request and holds it
// until the frame logic takes it.
// ----------------------------------------------------------------------------
module shfr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  shfr_in_if.sink         in_i,
  input  logic            down_ready_i,
  output logic            item_valid_o,
  output shfr_pkg::item_t item_o
);
  import shfr_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The register takes a new request whenever it is empty or being drained.
  assign in_i.ready = !valid_q || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.rx_byte <= in_i.rx_byte;
      item_q.time_ms <= in_i.time_ms;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ src/shfr_core.sv @@
// ----------------------------------------------------------------------------
// Frame parser core
// Holds the parser state, works out the next state and the result for one
// byte in a single pass, and registers the result for the output channel.
// ----------------------------------------------------------------------------
module shfr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shfr_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  shfr_pkg::item_t item_i,
  output logic            ready_o,
  shfr_out_if.source      out_o
);
  import shfr_pkg::*;

  // Parser state.
  logic [7:0]          prev_q, prev_d;
  logic                coll_q, coll_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] end_q, end_d;
  logic [7:0]          sum_q, sum_d;
  logic [31:0]         start_q, start_d;

  // Result register.
  logic    out_valid_q;
  result_t res_q, res_d;

  logic        advance;
  logic [31:0] elapsed;

  assign ready_o = !out_valid_q || out_o.ready;
  assign advance = item_valid_i && ready_o;
  assign elapsed = item_i.time_ms - start_q;

  // Data handling first, then sync detection on the same byte.
  always_comb begin
    prev_d  = item_i.rx_byte;
    coll_d  = coll_q;
    pos_d   = pos_q;
    end_d   = end_q;
    sum_d   = sum_q;
    start_d = start_q;
    res_d   = '0;

    if (coll_q) begin
      if (pos_q == LenPos) begin
        // Length byte: fix the checksum position and restart the sum.
        end_d          = {1'b0, item_i.rx_byte} + HeaderOverhead;
        pos_d          = LenPos + 9'd1;
        sum_d          = '0;
        res_d.wr_valid = 1'b1;
        res_d.wr_index = LenPos;
        res_d.wr_data  = item_i.rx_byte;
      end else if (pos_q < end_q) begin
        pos_d          = pos_q + 9'd1;
        sum_d          = sum_q + item_i.rx_byte;
        res_d.wr_valid = 1'b1;
        res_d.wr_index = pos_q;
        res_d.wr_data  = item_i.rx_byte;
      end else if (pos_q == end_q) begin
        // Checksum byte closes the frame.
        coll_d           = 1'b0;
        pos_d            = '0;
        res_d.wr_valid   = 1'b1;
        res_d.wr_index   = pos_q;
        res_d.wr_data    = item_i.rx_byte;
        res_d.frame_done = 1'b1;
        res_d.frame_good = (sum_q == item_i.rx_byte);
      end
    end

    if (prev_q == SyncFirst && item_i.rx_byte == SyncSecond) begin
      if (!coll_d) begin
        coll_d  = 1'b1;
        pos_d   = LenPos;
        start_d = item_i.time_ms;
      end else if (elapsed > {16'd0, cfg_i.resync_timeout}) begin
        // A sync pair mid-frame restarts only once the timeout has run out.
        pos_d   = LenPos;
        start_d = item_i.time_ms;
      end
    end

    res_d.in_frame = coll_d;
  end

  // Control state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      coll_q      <= 1'b0;
      pos_q       <= '0;
      end_q       <= '0;
      sum_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        out_valid_q <= item_valid_i;
      end
      if (advance) begin
        prev_q  <= prev_d;
        coll_q  <= coll_d;
        pos_q   <= pos_d;
        end_q   <= end_d;
        sum_q   <= sum_d;
        start_q <= start_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.wr_valid   = res_q.wr_valid;
  assign out_o.wr_index   = res_q.wr_index;
  assign out_o.wr_data    = res_q.wr_data;
  assign out_o.frame_done = res_q.frame_done;
  assign out_o.frame_good = res_q.frame_good;
  assign out_o.in_frame   = res_q.in_frame;

endmodule

@@ src/sync_header_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// Sync-header frame receiver
// Parses EB 90 / length / payload / additive checksum frames one byte at a
// time and reports buffer writes and frame completion.
// ----------------------------------------------------------------------------
// Each request carries one received byte and its millisecond timestamp and
// produces exactly one result, passing through an input register, then the
// parser logic and a result register. A new byte is taken every cycle while
// the result channel keeps draining; the sustained rate is one byte per cycle,
// set by the state update in the parser core. Bytes from the length byte
// onward are reported as writes at their frame position, and the checksum
// byte reports frame end and checksum match. The resynchronisation timeout
// register (address 0, reset 2 ms) sets how long after a frame start a fresh
// sync pair may restart the frame; write it only while idle.
module sync_header_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  shfr_in_if.sink                        in_i,
  shfr_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shfr_pkg::AddrWidth-1:0] paddr,
  input  logic [shfr_pkg::DataWidth-1:0] pwdata,
  output logic [shfr_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import shfr_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  core_ready;

  // Register block.
  shfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  shfr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .down_ready_i (core_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Parser and result register.
  shfr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .ready_o      (core_ready),
    .out_o        (out_o)
  );

endmodule
